// ----- hdl/cswq_pkg.sv -----
// Shared definitions for the counting semaphore block with FIFO wait queues.
// Holds status and function codes, register indexes, field widths and defaults.
// Depends on nothing.
`timescale 1ns / 1ps

package cswq_pkg;

   localparam int NUM_SEMAPHORES_DEF = 5;
   localparam int WAIT_DEPTH_DEF     = 16;
   localparam int PID_WIDTH_DEF      = 8;

   localparam int SEM_ID_W = 3;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;
   localparam int INIT_W   = 7;
   localparam int MASK_W   = 5;

   localparam int CSR_USED_MASK = 0;
   localparam int CSR_INIT_BASE = 1;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 8'sd127;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN  = -8'sd128;
   localparam logic signed [COUNT_W-1:0] COUNT_ZERO = 8'sd0;
   localparam logic signed [COUNT_W-1:0] COUNT_ONE  = 8'sd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BAD_ID   = 3'd1,
      ST_UNINIT   = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef enum logic {
      FUNC_P = 1'b0,
      FUNC_V = 1'b1
   } func_type;

endpackage

// ----- hdl/counting_semaphore_wait_queues_core.sv -----
// Top level of the counting semaphore bank; each semaphore keeps a FIFO of waiters.
// Waiter IDs live in one synchronous memory; counts and queue pointers in registers.
// Depends on cswq_pkg.
// A result passes through the p1 stage registers and then the output registers.
// Throughput: one request per cycle while req_stall is low; the count and pointer update
// for a semaphore completes in the accept cycle, and the waiter memory read is registered with p1.
// Reset clears all counts, queue pointers, fill levels and the used mask at once;
// the waiter memory is not cleared and no clearing pass is needed.
`timescale 1ns / 1ps

module counting_semaphore_wait_queues_core
   import cswq_pkg::*;
#(
   parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
   parameter int WAIT_DEPTH     = WAIT_DEPTH_DEF,
   parameter int PID_WIDTH      = PID_WIDTH_DEF,
   localparam int CSR_IDX_W     = $clog2(NUM_SEMAPHORES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [SEM_ID_W-1:0]  req_sem_id,
   input  logic [PID_WIDTH-1:0] req_caller_pid,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_caller_blocked,
   output logic                 rsp_woke_valid,
   output logic [PID_WIDTH-1:0] rsp_woke_pid,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [INIT_W-1:0]    csr_wdata
);

   localparam int SEM_IDX_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
   localparam int ID_EXT_W   = (SEM_IDX_W > SEM_ID_W) ? SEM_IDX_W : SEM_ID_W;
   localparam int SLOT_W     = $clog2(WAIT_DEPTH);
   localparam int FILL_W     = $clog2(WAIT_DEPTH + 1);
   localparam int MEM_DEPTH  = NUM_SEMAPHORES * WAIT_DEPTH;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);

   logic signed [COUNT_W-1:0] count_ff [NUM_SEMAPHORES];
   logic signed [COUNT_W-1:0] count_in [NUM_SEMAPHORES];
   logic [SLOT_W-1:0]         head_ff  [NUM_SEMAPHORES];
   logic [SLOT_W-1:0]         head_in  [NUM_SEMAPHORES];
   logic [SLOT_W-1:0]         tail_ff  [NUM_SEMAPHORES];
   logic [SLOT_W-1:0]         tail_in  [NUM_SEMAPHORES];
   logic [FILL_W-1:0]         fill_ff  [NUM_SEMAPHORES];
   logic [FILL_W-1:0]         fill_in  [NUM_SEMAPHORES];
   logic [NUM_SEMAPHORES-1:0] used_mask_ff;
   logic [NUM_SEMAPHORES-1:0] used_mask_in;

   logic [PID_WIDTH-1:0]      wait_mem [MEM_DEPTH];
   logic [PID_WIDTH-1:0]      mem_rdata_ff;
   logic                      mem_we;
   logic                      mem_re;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [ADDR_W-1:0]         mem_raddr;

   logic                      p1_valid_ff;
   logic                      p1_valid_in;
   status_type                p1_status_ff;
   status_type                p1_status_in;
   logic                      p1_blocked_ff;
   logic                      p1_blocked_in;
   logic                      p1_pop_ff;
   logic                      p1_pop_in;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   status_type                out_status_ff;
   logic                      out_blocked_ff;
   logic                      out_woke_ff;
   logic [PID_WIDTH-1:0]      out_woke_pid_ff;

   logic                      out_free;
   logic                      req_accept;
   logic [ID_EXT_W-1:0]       id_ext;
   logic [SEM_IDX_W-1:0]      sem_idx;
   logic                      id_ok;
   logic signed [COUNT_W-1:0] cur_count;
   logic [SLOT_W-1:0]         cur_head;
   logic [SLOT_W-1:0]         cur_tail;
   logic [FILL_W-1:0]         cur_fill;
   logic [NUM_SEMAPHORES+MASK_W-1:0] mask_wide;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign req_stall  = p1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign id_ext    = ID_EXT_W'(req_sem_id);
   assign sem_idx   = id_ext[SEM_IDX_W-1:0];
   assign id_ok     = (id_ext < ID_EXT_W'(NUM_SEMAPHORES));
   assign cur_count = count_ff[sem_idx];
   assign cur_head  = head_ff[sem_idx];
   assign cur_tail  = tail_ff[sem_idx];
   assign cur_fill  = fill_ff[sem_idx];
   assign mask_wide = (NUM_SEMAPHORES + MASK_W)'(csr_wdata[MASK_W-1:0]);

   assign mem_waddr = ADDR_W'(sem_idx) * ADDR_W'(WAIT_DEPTH) + ADDR_W'(cur_tail);
   assign mem_raddr = ADDR_W'(sem_idx) * ADDR_W'(WAIT_DEPTH) + ADDR_W'(cur_head);

   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      used_mask_in  = used_mask_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      p1_status_in  = ST_OK;
      p1_blocked_in = 1'b0;
      p1_pop_in     = 1'b0;

      if (!id_ok) begin
         p1_status_in = ST_BAD_ID;
      end else if (!used_mask_ff[sem_idx]) begin
         p1_status_in = ST_UNINIT;
      end else if (req_func == FUNC_P) begin
         if (cur_count <= COUNT_ZERO && cur_fill == FILL_W'(WAIT_DEPTH)) begin
            p1_status_in = ST_FULL;
         end else if (cur_count == COUNT_MIN) begin
            p1_status_in = ST_OVERFLOW;
         end else begin
            if (req_accept) begin
               count_in[sem_idx] = cur_count - COUNT_ONE;
            end
            if (cur_count <= COUNT_ZERO) begin
               p1_blocked_in = 1'b1;
               if (req_accept) begin
                  mem_we           = 1'b1;
                  tail_in[sem_idx] = (cur_tail == SLOT_W'(WAIT_DEPTH - 1)) ?
                                     '0 : cur_tail + SLOT_W'(1);
                  fill_in[sem_idx] = cur_fill + FILL_W'(1);
               end
            end
         end
      end else begin
         if (cur_count == COUNT_MAX) begin
            p1_status_in = ST_OVERFLOW;
         end else begin
            if (req_accept) begin
               count_in[sem_idx] = cur_count + COUNT_ONE;
            end
            if (cur_count < COUNT_ZERO) begin
               if (cur_fill == '0) begin
                  p1_status_in = ST_EMPTY;
               end else begin
                  p1_pop_in = 1'b1;
                  if (req_accept) begin
                     mem_re           = 1'b1;
                     head_in[sem_idx] = (cur_head == SLOT_W'(WAIT_DEPTH - 1)) ?
                                        '0 : cur_head + SLOT_W'(1);
                     fill_in[sem_idx] = cur_fill - FILL_W'(1);
                  end
               end
            end
         end
      end

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_IDX_W'(CSR_USED_MASK)) begin
            used_mask_in = mask_wide[NUM_SEMAPHORES-1:0];
         end
         for (int k = 0; k < NUM_SEMAPHORES; k++) begin
            if (csr_index == CSR_IDX_W'(CSR_INIT_BASE + k)) begin
               count_in[k]     = COUNT_W'(csr_wdata);
               head_in[k]      = '0;
               tail_in[k]      = '0;
               fill_in[k]      = '0;
               used_mask_in[k] = 1'b1;
            end
         end
      end

      if (req_accept) begin
         p1_valid_in = 1'b1;
      end else if (out_free) begin
         p1_valid_in = 1'b0;
      end else begin
         p1_valid_in = p1_valid_ff;
      end

      if (out_free) begin
         out_valid_in = p1_valid_ff;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_SEMAPHORES; k++) begin
            count_ff[k] <= COUNT_ZERO;
            head_ff[k]  <= '0;
            tail_ff[k]  <= '0;
            fill_ff[k]  <= '0;
         end
         used_mask_ff <= '0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         used_mask_ff <= used_mask_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wait_mem[mem_waddr] <= req_caller_pid;
      end
      if (mem_re) begin
         mem_rdata_ff <= wait_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_status_ff  <= p1_status_in;
         p1_blocked_ff <= p1_blocked_in;
         p1_pop_ff     <= p1_pop_in;
      end
      if (out_free && p1_valid_ff) begin
         out_status_ff   <= p1_status_ff;
         out_blocked_ff  <= p1_blocked_ff;
         out_woke_ff     <= p1_pop_ff;
         out_woke_pid_ff <= p1_pop_ff ? mem_rdata_ff : '0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_caller_blocked = out_blocked_ff;
   assign rsp_woke_valid     = out_woke_ff;
   assign rsp_woke_pid       = out_woke_pid_ff;

endmodule
